// ===== rtl/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// spe_pkg
// Shared constants, types and elaboration-time table builders for the
// sine product evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

   // Sizes
   localparam int MAX_DIMENSIONS = 3;
   localparam int CORDIC_STEPS   = 30;
   localparam int DATA_W         = 32;
   localparam int CSR_INDEX_W    = 3;
   localparam int XY_W           = 48;   // CORDIC x/y, Q40
   localparam int Z_W            = 52;   // CORDIC residual angle, Q48
   localparam int REDUCE_STEPS   = 13;   // conditional subtracts of 2pi << k

   // Latencies
   localparam int LANE_LATENCY  = 4 + REDUCE_STEPS + CORDIC_STEPS;
   localparam int MERGE_LATENCY = 1 + 2 * MAX_DIMENSIONS;
   localparam int PIPE_DEPTH    = LANE_LATENCY + MERGE_LATENCY;

   // Fixed-point constants
   localparam logic [63:0] PI_Q48         = 64'h0003243F6A8885A3;
   localparam logic [63:0] TWO_PI_Q48     = 64'h0006487ED5110B46;
   localparam logic [63:0] QUARTER_PI_Q48 = 64'h0000C90FDAA22169;
   localparam logic [63:0] REDUCE_BIAS    = TWO_PI_Q48 << (REDUCE_STEPS - 1);
   localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh40000000;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONSTANT_MODE   = 3'd0,
      CSR_DIMENSION_COUNT = 3'd1,
      CSR_WAVE_NUMBER_0   = 3'd2,
      CSR_WAVE_NUMBER_1   = 3'd3,
      CSR_WAVE_NUMBER_2   = 3'd4
   } csr_index_type;

   // Controls seen by the merging stage
   typedef struct packed {
      logic       constant_mode;
      logic [1:0] dimension_count;
   } merge_ctrl_type;

   // Restoring unsigned divide, used only while building constant tables
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v     = val;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (bit_v > v) bit_v = bit_v >> 2;
      end
      for (int n = 0; n < 32; n++) begin
         if (bit_v != 64'd0) begin
            if (v >= res + bit_v) begin
               v   = v - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // atan(2^-i) in Q48 from the alternating series in Q60
   function automatic logic signed [63:0] cordic_angle(input int i);
      logic signed [63:0] s;
      logic [63:0]        term;
      int                 span;
      s = '0;
      if (i == 0) return signed'(QUARTER_PI_Q48);
      for (int k = 0; k < 31; k++) begin
         span = i * (2 * k + 1);
         if (span <= 60) begin
            term = udiv64(64'd1 << (60 - span), 64'(2 * k + 1));
            if ((k & 1) != 0) s = s - signed'(term);
            else              s = s + signed'(term);
         end
      end
      return (s + 64'sd2048) >>> 12;
   endfunction

   // Start value of x: inverse CORDIC gain, Q40
   function automatic logic signed [XY_W-1:0] cordic_x_start();
      logic [63:0] p;
      logic [63:0] g;
      logic [63:0] k;
      p = 64'd1 << 62;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         p = p + (p >> (2 * i));
      end
      g = isqrt64(p);
      k = udiv64(64'd1 << 63, g);
      return XY_W'(signed'(k << 8));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sine_product_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// sine_product_evaluator_core
// Product of CORDIC sines of wave number times coordinate, one point a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Points arrive on the req_ channel (valid/stall); each transfer carries
//   three Q8.24 coordinates and yields exactly one Q2.30 result on the rsp_
//   channel, in order. Only the first dimension_count coordinates count;
//   constant_mode returns 1.0.
//   Registers are loaded through the csr_ write port (index, data, enable);
//   the user loads them only while no point is in flight (the block does not enforce this).
//   The pipeline is PIPE_DEPTH deep: each dimension lane (multiply,
//   bias, 13 reduction stages, fold, 30 CORDIC stages, rounding) feeds the
//   merging multiplier chain. Throughput is one point per cycle when not stalled.
//   When rsp_stall is high while a result is shown, the whole pipeline
//   holds and req_stall rises in the same cycle; nothing is dropped.
//   Reset empties the pipeline and restores constant_mode 0,
//   dimension_count 1 and zero wave numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_product_evaluator_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [spe_pkg::DATA_W-1:0]      req_coordinate_0,
   input  wire logic signed [spe_pkg::DATA_W-1:0]      req_coordinate_1,
   input  wire logic signed [spe_pkg::DATA_W-1:0]      req_coordinate_2,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [spe_pkg::DATA_W-1:0]           rsp_field_value,
   input  wire logic                                   csr_write_enable,
   input  wire logic [spe_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [spe_pkg::DATA_W-1:0]             csr_write_data
);
   import spe_pkg::*;

   logic                     constant_mode_ff;
   logic [1:0]               dimension_count_ff;
   logic signed [DATA_W-1:0] wave_number_ff [MAX_DIMENSIONS];
   logic [PIPE_DEPTH-1:0]    valid_ff;
   logic                     enable;
   logic                     req_accept;
   logic signed [DATA_W-1:0] coordinate [MAX_DIMENSIONS];
   logic signed [DATA_W-1:0] sine [MAX_DIMENSIONS];
   merge_ctrl_type           ctrl;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         constant_mode_ff   <= 1'b0;
         dimension_count_ff <= 2'd1;
         for (int d = 0; d < MAX_DIMENSIONS; d++) wave_number_ff[d] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CONSTANT_MODE:   constant_mode_ff   <= csr_write_data[0];
            CSR_DIMENSION_COUNT: dimension_count_ff <= csr_write_data[1:0];
            CSR_WAVE_NUMBER_0:   wave_number_ff[0]  <= signed'(csr_write_data);
            CSR_WAVE_NUMBER_1:   wave_number_ff[1]  <= signed'(csr_write_data);
            CSR_WAVE_NUMBER_2:   wave_number_ff[2]  <= signed'(csr_write_data);
            default: ;
         endcase
      end
   end

   // Pipeline advances unless the shown result is stalled
   assign enable     = !(valid_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall  = !enable;
   assign req_accept = req_valid && enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_accept};
      end
   end

   assign coordinate[0] = req_coordinate_0;
   assign coordinate[1] = req_coordinate_1;
   assign coordinate[2] = req_coordinate_2;

   // One lane per dimension
   for (genvar d = 0; d < MAX_DIMENSIONS; d++) begin : g_lane
      spe_lane u_lane (
         .clock       (clock),
         .enable      (enable),
         .wave_number (wave_number_ff[d]),
         .coordinate  (coordinate[d]),
         .sine        (sine[d])
      );
   end

   assign ctrl.constant_mode   = constant_mode_ff;
   assign ctrl.dimension_count = dimension_count_ff;

   spe_merge u_merge (
      .clock   (clock),
      .enable  (enable),
      .ctrl    (ctrl),
      .sine    (sine),
      .product (rsp_field_value)
   );

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

`ifndef SYNTHESIS
   // constant mode always yields exactly one
   a_constant_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && constant_mode_ff) |-> (rsp_field_value == ONE_Q30))
      else $error("constant mode result is not 1.0");

   // an empty product is one
   a_zero_dims: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dimension_count_ff == 2'd0) |-> (rsp_field_value == ONE_Q30))
      else $error("zero-dimension result is not 1.0");

   // results stay within +-1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_field_value <= ONE_Q30 && rsp_field_value >= -ONE_Q30))
      else $error("result out of range");

   // a stalled result freezes the pipeline valid bits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/spe_lane.sv =====
// ----------------------------------------------------------------------------
// spe_lane
// One dimension: phase multiply, modulo-2pi reduction, quadrant fold and a
// fully pipelined rotation CORDIC giving the sine in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_lane (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic signed [spe_pkg::DATA_W-1:0] wave_number,
   input  wire logic signed [spe_pkg::DATA_W-1:0] coordinate,
   output logic signed [spe_pkg::DATA_W-1:0]      sine
);
   import spe_pkg::*;

   localparam logic signed [XY_W-1:0] X_START = cordic_x_start();

   logic signed [63:0]     phase_in;
   logic signed [63:0]     phase_ff;
   logic [63:0]            red_ff [REDUCE_STEPS+1];
   logic signed [Z_W-1:0]  half_in;
   logic signed [Z_W-1:0]  fold_in;
   logic signed [XY_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] round_in;
   logic signed [DATA_W-1:0] sine_in;
   logic signed [DATA_W-1:0] sine_ff;

   // Phase product, exact Q16.48
   assign phase_in = wave_number * coordinate;

   always_ff @(posedge clock) begin
      if (enable) begin
         phase_ff  <= phase_in;
         // bias by a multiple of 2pi so the value is non-negative
         red_ff[0] <= phase_ff + REDUCE_BIAS;
      end
   end

   // Restoring reduction modulo 2pi, one multiple per stage
   for (genvar j = 0; j < REDUCE_STEPS; j++) begin : g_reduce
      localparam logic [63:0] SUB = TWO_PI_Q48 << (REDUCE_STEPS - 1 - j);
      logic [64:0] diff_in;
      assign diff_in = {1'b0, red_ff[j]} - {1'b0, SUB};
      always_ff @(posedge clock) begin
         if (enable) red_ff[j+1] <= diff_in[64] ? red_ff[j] : diff_in[63:0];
      end
   end

   // Move to (-pi, pi], then fold into [-pi/2, pi/2]
   always_comb begin
      half_in = signed'(Z_W'(red_ff[REDUCE_STEPS]));
      if (half_in > signed'(Z_W'(PI_Q48))) half_in = half_in - signed'(Z_W'(TWO_PI_Q48));
      fold_in = half_in;
      if ((half_in <<< 1) > signed'(Z_W'(PI_Q48))) begin
         fold_in = signed'(Z_W'(PI_Q48)) - half_in;
      end else if ((half_in <<< 1) < -signed'(Z_W'(PI_Q48))) begin
         fold_in = -signed'(Z_W'(PI_Q48)) - half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= X_START;
         y_ff[0] <= '0;
         z_ff[0] <= fold_in;
      end
   end

   // CORDIC rotation stages
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [Z_W-1:0] ANG = Z_W'(cordic_angle(i));
      logic signed [XY_W-1:0] dx_in;
      logic signed [XY_W-1:0] dy_in;
      assign dx_in = y_ff[i] >>> i;
      assign dy_in = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx_in;
               y_ff[i+1] <= y_ff[i] + dy_in;
               z_ff[i+1] <= z_ff[i] - ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx_in;
               y_ff[i+1] <= y_ff[i] - dy_in;
               z_ff[i+1] <= z_ff[i] + ANG;
            end
         end
      end
   end

   // Round Q40 to Q30 and clamp to +-1.0
   always_comb begin
      round_in = (y_ff[CORDIC_STEPS] + XY_W'(512)) >>> 10;
      if (round_in > XY_W'(ONE_Q30))       sine_in = ONE_Q30;
      else if (round_in < -XY_W'(ONE_Q30)) sine_in = -ONE_Q30;
      else                                 sine_in = round_in[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

// ===== rtl/spe_merge.sv =====
// ----------------------------------------------------------------------------
// spe_merge
// Merging stage: multiplies the lane sines in use (none in constant mode)
// into one Q2.30 product, one multiply and one rounding stage per dimension.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_merge (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire spe_pkg::merge_ctrl_type           ctrl,
   input  wire logic signed [spe_pkg::DATA_W-1:0] sine [spe_pkg::MAX_DIMENSIONS],
   output logic signed [spe_pkg::DATA_W-1:0]      product
);
   import spe_pkg::*;

   logic signed [DATA_W-1:0] prod_ff [MAX_DIMENSIONS+1];

   always_ff @(posedge clock) begin
      if (enable) prod_ff[0] <= ONE_Q30;
   end

   for (genvar d = 0; d < MAX_DIMENSIONS; d++) begin : g_dim
      logic signed [DATA_W-1:0] line_ff [2*d+1];
      logic signed [63:0]       mult_ff;
      logic signed [DATA_W-1:0] pass_ff;
      logic signed [63:0]       round_in;
      logic                     use_in;

      // align this lane's sine with the running product
      always_ff @(posedge clock) begin
         if (enable) begin
            line_ff[0] <= sine[d];
            for (int k = 1; k <= 2 * d; k++) line_ff[k] <= line_ff[k-1];
         end
      end

      assign use_in   = !ctrl.constant_mode && (ctrl.dimension_count > 2'(d));
      assign round_in = (mult_ff + 64'sd536870912) >>> 30;

      always_ff @(posedge clock) begin
         if (enable) begin
            mult_ff    <= prod_ff[d] * line_ff[2*d];
            pass_ff    <= prod_ff[d];
            prod_ff[d+1] <= use_in ? round_in[DATA_W-1:0] : pass_ff;
         end
      end
   end

   assign product = prod_ff[MAX_DIMENSIONS];

endmodule

`default_nettype wire
